/* design/mieu_pkg.sv */
package mieu_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned RegIndexWidth = 5;
  localparam logic [RegIndexWidth-1:0] LinkRegister = 5'd31;
  localparam logic [WordWidth-1:0] HighNibbleMask = 32'hf000_0000;

  typedef enum logic [1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_PASSED   = 2'd2,
    STATUS_UNKNOWN  = 2'd3
  } status_t;

  typedef struct packed {
    logic [WordWidth-1:0] instruction_word;
    logic [WordWidth-1:0] source_value;
    logic [WordWidth-1:0] target_value;
    logic [WordWidth-1:0] next_address;
  } instr_t;

  typedef struct packed {
    logic                     write_enable;
    logic [RegIndexWidth-1:0] write_register;
    logic [WordWidth-1:0]     write_value;
    logic                     branch_taken;
    logic [WordWidth-1:0]     branch_target;
    status_t                  status;
  } result_t;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_COP0    = 6'h10;
  localparam logic [5:0] OP_COP1    = 6'h11;
  localparam logic [5:0] OP_COP2    = 6'h12;
  localparam logic [5:0] OP_COP3    = 6'h13;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LWL     = 6'h22;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_LWR     = 6'h26;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SWL     = 6'h2A;
  localparam logic [5:0] OP_SW      = 6'h2B;
  localparam logic [5:0] OP_SWR     = 6'h2E;
  localparam logic [5:0] OP_LWC0    = 6'h30;
  localparam logic [5:0] OP_LWC1    = 6'h31;
  localparam logic [5:0] OP_LWC2    = 6'h32;
  localparam logic [5:0] OP_LWC3    = 6'h33;
  localparam logic [5:0] OP_SWC0    = 6'h38;
  localparam logic [5:0] OP_SWC1    = 6'h39;
  localparam logic [5:0] OP_SWC2    = 6'h3A;
  localparam logic [5:0] OP_HLE     = 6'h3B;

  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_HLE     = 6'h0B;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_BREAK   = 6'h0D;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;
  localparam logic [5:0] FN_SLTU    = 6'h2B;

endpackage

/* design/mieu_stage.sv */
module mieu_stage
  import mieu_pkg::*;
#(
  parameter type payload_t = instr_t
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     up_valid,
  output logic     up_ready,
  input  payload_t up_data,
  output logic     down_valid,
  input  logic     down_ready,
  output payload_t down_data
);

  logic     valid;
  payload_t data;

  assign up_ready   = !valid || down_ready;
  assign down_valid = valid;
  assign down_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= up_data;
    end
  end

endmodule

/* design/mieu_exec.sv */
module mieu_exec
  import mieu_pkg::*;
(
  input  instr_t  instr,
  output result_t result
);

  logic [WordWidth-1:0]     code;
  logic [WordWidth-1:0]     s;
  logic [WordWidth-1:0]     t;
  logic [WordWidth-1:0]     next;
  logic [5:0]               op;
  logic [5:0]               funct;
  logic [RegIndexWidth-1:0] rt;
  logic [RegIndexWidth-1:0] rd;
  logic [RegIndexWidth-1:0] amount;
  logic [WordWidth-1:0]     immu;
  logic [WordWidth-1:0]     imms;
  logic [WordWidth-1:0]     btarget;
  logic [WordWidth-1:0]     jtarget;
  logic [WordWidth-1:0]     link;
  logic [WordWidth-1:0]     sum;
  logic [WordWidth-1:0]     diff;
  logic [WordWidth-1:0]     sumi;
  logic                     sum_ovf;
  logic                     diff_ovf;
  logic                     sumi_ovf;
  logic                     cond;
  logic                     we;
  logic [RegIndexWidth-1:0] dest;
  logic [WordWidth-1:0]     val;
  logic                     taken;
  logic [WordWidth-1:0]     target;
  status_t                  status;
  logic                     write_ok;

  assign code    = instr.instruction_word;
  assign s       = instr.source_value;
  assign t       = instr.target_value;
  assign next    = instr.next_address;
  assign op      = code[31:26];
  assign rt      = code[20:16];
  assign rd      = code[15:11];
  assign funct   = code[5:0];
  assign amount  = funct[2] ? s[RegIndexWidth-1:0] : code[10:6];
  assign immu    = {16'h0000, code[15:0]};
  assign imms    = {{16{code[15]}}, code[15:0]};
  assign btarget = next + {imms[WordWidth-3:0], 2'b00};
  assign jtarget = {4'h0, code[25:0], 2'b00} | (next & HighNibbleMask);
  assign link    = next + 32'd4;
  assign sum     = s + t;
  assign diff    = s - t;
  assign sumi    = s + imms;
  assign sum_ovf  = (s[31] ^ sum[31]) & (t[31] ^ sum[31]);
  assign diff_ovf = (s[31] ^ t[31]) & (s[31] ^ diff[31]);
  assign sumi_ovf = (s[31] ^ sumi[31]) & (imms[31] ^ sumi[31]);
  assign cond     = rt[0] ? !s[31] : s[31];

  always_comb begin
    we     = 1'b0;
    dest   = '0;
    val    = '0;
    taken  = 1'b0;
    target = '0;
    status = STATUS_DONE;
    unique case (op) inside
      OP_SPECIAL: begin
        dest = rd;
        unique case (funct) inside
          FN_SLL, FN_SLLV: begin
            we  = 1'b1;
            val = t << amount;
          end
          FN_SRL, FN_SRLV: begin
            we  = 1'b1;
            val = t >> amount;
          end
          FN_SRA, FN_SRAV: begin
            we  = 1'b1;
            val = $unsigned($signed(t) >>> amount);
          end
          FN_JR: begin
            taken  = 1'b1;
            target = s;
          end
          FN_JALR: begin
            we     = 1'b1;
            val    = link;
            taken  = 1'b1;
            target = s;
          end
          FN_HLE, FN_SYSCALL, FN_BREAK, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO,
          FN_MULT, FN_MULTU, FN_DIV, FN_DIVU: begin
            status = STATUS_PASSED;
          end
          FN_ADD: begin
            if (sum_ovf) begin
              status = STATUS_OVERFLOW;
            end else begin
              we  = 1'b1;
              val = sum;
            end
          end
          FN_ADDU: begin
            we  = 1'b1;
            val = sum;
          end
          FN_SUB: begin
            if (diff_ovf) begin
              status = STATUS_OVERFLOW;
            end else begin
              we  = 1'b1;
              val = diff;
            end
          end
          FN_SUBU: begin
            we  = 1'b1;
            val = diff;
          end
          FN_AND: begin
            we  = 1'b1;
            val = s & t;
          end
          FN_OR: begin
            we  = 1'b1;
            val = s | t;
          end
          FN_XOR: begin
            we  = 1'b1;
            val = s ^ t;
          end
          FN_NOR: begin
            we  = 1'b1;
            val = ~(s | t);
          end
          FN_SLT: begin
            we  = 1'b1;
            val = {31'd0, $signed(s) < $signed(t)};
          end
          FN_SLTU: begin
            we  = 1'b1;
            val = {31'd0, s < t};
          end
          default: begin
            status = STATUS_UNKNOWN;
          end
        endcase
      end
      OP_REGIMM: begin
        if (rt[3:1] == 3'b000) begin
          dest = LinkRegister;
          we   = rt[4];
          val  = link;
          if (cond) begin
            taken  = 1'b1;
            target = btarget;
          end
        end else begin
          status = STATUS_UNKNOWN;
        end
      end
      OP_J: begin
        taken  = 1'b1;
        target = jtarget;
      end
      OP_JAL: begin
        we     = 1'b1;
        dest   = LinkRegister;
        val    = link;
        taken  = 1'b1;
        target = jtarget;
      end
      OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
        unique case (op) inside
          OP_BEQ:  taken = (s == t);
          OP_BNE:  taken = (s != t);
          OP_BLEZ: taken = s[31] || (s == '0);
          default: taken = !s[31] && (s != '0);
        endcase
        target = taken ? btarget : '0;
      end
      OP_ADDI: begin
        dest = rt;
        if (sumi_ovf) begin
          status = STATUS_OVERFLOW;
        end else begin
          we  = 1'b1;
          val = sumi;
        end
      end
      OP_ADDIU: begin
        we   = 1'b1;
        dest = rt;
        val  = sumi;
      end
      OP_SLTI: begin
        we   = 1'b1;
        dest = rt;
        val  = {31'd0, $signed(s) < $signed(imms)};
      end
      OP_SLTIU: begin
        we   = 1'b1;
        dest = rt;
        val  = {31'd0, s < imms};
      end
      OP_ANDI: begin
        we   = 1'b1;
        dest = rt;
        val  = s & immu;
      end
      OP_ORI: begin
        we   = 1'b1;
        dest = rt;
        val  = s | immu;
      end
      OP_XORI: begin
        we   = 1'b1;
        dest = rt;
        val  = s ^ immu;
      end
      OP_LUI: begin
        we   = 1'b1;
        dest = rt;
        val  = {code[15:0], 16'h0000};
      end
      OP_COP0, OP_COP1, OP_COP2, OP_COP3,
      OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR,
      OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR,
      OP_LWC0, OP_LWC1, OP_LWC2, OP_LWC3,
      OP_SWC0, OP_SWC1, OP_SWC2, OP_HLE: begin
        status = STATUS_PASSED;
      end
      default: begin
        status = STATUS_UNKNOWN;
      end
    endcase
  end

  assign write_ok = we && (dest != '0);

  assign result.write_enable   = write_ok;
  assign result.write_register = write_ok ? dest : '0;
  assign result.write_value    = write_ok ? val : '0;
  assign result.branch_taken   = taken;
  assign result.branch_target  = target;
  assign result.status         = status;

endmodule

/* design/mips_integer_execute_unit.sv */
// Channel   Direction  Handshake                   Payload
// instr     in         instr_valid / instr_ready   instr_t
// result    out        result_valid / result_ready result_t
//
// One instruction per cycle is accepted when both registers can advance.
// An instruction passes through an input register, then decode and ALU logic
// into the result register. Reset is synchronous and clears both valid flags.
// A stalled result holds in place while the input register keeps taking a
// transaction as long as it is empty or drains in the same cycle.
module mips_integer_execute_unit
  import mieu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    instr_valid,
  output logic    instr_ready,
  input  instr_t  instr,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic    held_valid;
  logic    held_ready;
  instr_t  held;
  result_t computed;

  mieu_stage #(
    .payload_t (instr_t)
  ) u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (instr_valid),
    .up_ready   (instr_ready),
    .up_data    (instr),
    .down_valid (held_valid),
    .down_ready (held_ready),
    .down_data  (held)
  );

  mieu_exec u_exec (
    .instr  (held),
    .result (computed)
  );

  mieu_stage #(
    .payload_t (result_t)
  ) u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (held_valid),
    .up_ready   (held_ready),
    .up_data    (computed),
    .down_valid (result_valid),
    .down_ready (result_ready),
    .down_data  (result)
  );

endmodule

/* design/mieu_checker.sv */
module mieu_checker
  import mieu_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("Stalled result transaction changed.");

  a_no_r0: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.write_enable |-> result.write_register != '0)
    else $error("Write to register zero.");

  a_quiet_write: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.write_enable |->
      result.write_register == '0 && result.write_value == '0)
    else $error("Write fields nonzero without a write.");

  a_quiet_branch: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.branch_taken |-> result.branch_target == '0)
    else $error("Branch target nonzero without a branch.");

  a_status_side: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != STATUS_DONE |->
      !result.write_enable && !result.branch_taken)
    else $error("Trap or handoff produced a write or branch.");

endmodule

bind mips_integer_execute_unit mieu_checker u_mieu_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench
  import mieu_pkg::*;
();

  localparam int unsigned RandomItems = 1850;
  localparam int unsigned IdleLimit = 1000;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned HoldoffCycles = 80;
  localparam int unsigned HoldoffAfter = 300;
  localparam int unsigned NumFuncts = 29;
  localparam int unsigned NumOps = 39;
  localparam int unsigned NumComputeOps = 14;

  localparam logic [4:0] RI_BLTZ   = 5'd0;
  localparam logic [4:0] RI_BGEZ   = 5'd1;
  localparam logic [4:0] RI_UNUSED = 5'd2;
  localparam logic [4:0] RI_BLTZAL = 5'd16;
  localparam logic [4:0] RI_BGEZAL = 5'd17;
  localparam logic [5:0] FN_UNUSED = 6'h01;
  localparam logic [5:0] OP_UNUSED = 6'h3F;

  typedef struct {
    instr_t  item;
    bit      typed;
    result_t want;
  } directed_row_t;

  logic    clk;
  logic    rst = 1'b1;
  logic    instr_valid = 1'b0;
  logic    instr_ready;
  instr_t  instr = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  result_t       expected_results[$];
  directed_row_t directed_rows[$];
  int unsigned   accepted_count = 0;
  int unsigned   result_count = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   idle_cycles = 0;
  bit            holdoff_done = 1'b0;

  logic [5:0] special_functs [NumFuncts] = '{
    FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR,
    FN_HLE, FN_SYSCALL, FN_BREAK, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO,
    FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU,
    FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU
  };

  // The first NumComputeOps entries are the ones this unit executes itself.
  logic [5:0] main_opcodes [NumOps] = '{
    OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU,
    OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI,
    OP_COP0, OP_COP1, OP_COP2, OP_COP3, OP_LB, OP_LH, OP_LWL, OP_LW,
    OP_LBU, OP_LHU, OP_LWR, OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR,
    OP_LWC0, OP_LWC1, OP_LWC2, OP_LWC3, OP_SWC0, OP_SWC1, OP_SWC2, OP_HLE,
    OP_UNUSED
  };

  mips_integer_execute_unit dut (
    .clk          (clk),
    .rst          (rst),
    .instr_valid  (instr_valid),
    .instr_ready  (instr_ready),
    .instr        (instr),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic result_t predict_execution(instr_t item);
    result_t     r;
    logic [31:0] w, s, t, nxt, imm_zero, imm_sign, br_dest, jump_dest, link;
    logic [31:0] sum, wval, dest;
    logic [5:0]  opcode, funct;
    logic [4:0]  rt, rd, shamt, wreg;
    logic        we, taken;
    status_t     st;
    w = item.instruction_word;
    s = item.source_value;
    t = item.target_value;
    nxt = item.next_address;
    opcode = w[31:26];
    funct = w[5:0];
    rt = w[20:16];
    rd = w[15:11];
    shamt = w[10:6];
    imm_zero = {16'h0000, w[15:0]};
    imm_sign = {{16{w[15]}}, w[15:0]};
    br_dest = nxt + (imm_sign << 2);
    jump_dest = {nxt[31:28], w[25:0], 2'b00};
    link = nxt + 32'd4;
    we = 1'b0;
    wreg = '0;
    wval = '0;
    taken = 1'b0;
    dest = '0;
    st = STATUS_DONE;
    case (opcode)
      OP_SPECIAL: begin
        we = 1'b1;
        wreg = rd;
        case (funct)
          FN_SLL:  wval = t << shamt;
          FN_SRL:  wval = t >> shamt;
          FN_SRA:  wval = $signed(t) >>> shamt;
          FN_SLLV: wval = t << s[4:0];
          FN_SRLV: wval = t >> s[4:0];
          FN_SRAV: wval = $signed(t) >>> s[4:0];
          FN_JR: begin
            we = 1'b0;
            taken = 1'b1;
            dest = s;
          end
          FN_JALR: begin
            wval = link;
            taken = 1'b1;
            dest = s;
          end
          FN_HLE, FN_SYSCALL, FN_BREAK, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO,
          FN_MULT, FN_MULTU, FN_DIV, FN_DIVU: begin
            we = 1'b0;
            st = STATUS_PASSED;
          end
          FN_ADD: begin
            sum = s + t;
            wval = sum;
            if (s[31] == t[31] && sum[31] != s[31]) begin
              we = 1'b0;
              st = STATUS_OVERFLOW;
            end
          end
          FN_ADDU: wval = s + t;
          FN_SUB: begin
            sum = s - t;
            wval = sum;
            if (s[31] != t[31] && sum[31] != s[31]) begin
              we = 1'b0;
              st = STATUS_OVERFLOW;
            end
          end
          FN_SUBU: wval = s - t;
          FN_AND:  wval = s & t;
          FN_OR:   wval = s | t;
          FN_XOR:  wval = s ^ t;
          FN_NOR:  wval = ~(s | t);
          FN_SLT:  wval = {31'd0, $signed(s) < $signed(t)};
          FN_SLTU: wval = {31'd0, s < t};
          default: begin
            we = 1'b0;
            st = STATUS_UNKNOWN;
          end
        endcase
      end
      OP_REGIMM: begin
        if (rt == RI_BLTZ || rt == RI_BGEZ || rt == RI_BLTZAL || rt == RI_BGEZAL) begin
          if (rt[4]) begin
            we = 1'b1;
            wreg = LinkRegister;
            wval = link;
          end
          if (rt[0] ? !s[31] : s[31]) begin
            taken = 1'b1;
            dest = br_dest;
          end
        end else begin
          st = STATUS_UNKNOWN;
        end
      end
      OP_J: begin
        taken = 1'b1;
        dest = jump_dest;
      end
      OP_JAL: begin
        we = 1'b1;
        wreg = LinkRegister;
        wval = link;
        taken = 1'b1;
        dest = jump_dest;
      end
      OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
        case (opcode)
          OP_BEQ:  taken = (s == t);
          OP_BNE:  taken = (s != t);
          OP_BLEZ: taken = s[31] || s == 32'd0;
          default: taken = !s[31] && s != 32'd0;
        endcase
        dest = br_dest;
      end
      OP_ADDI: begin
        sum = s + imm_sign;
        if (s[31] == imm_sign[31] && sum[31] != s[31]) begin
          st = STATUS_OVERFLOW;
        end else begin
          we = 1'b1;
          wreg = rt;
          wval = sum;
        end
      end
      OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI: begin
        we = 1'b1;
        wreg = rt;
        case (opcode)
          OP_ADDIU: wval = s + imm_sign;
          OP_SLTI:  wval = {31'd0, $signed(s) < $signed(imm_sign)};
          OP_SLTIU: wval = {31'd0, s < imm_sign};
          OP_ANDI:  wval = s & imm_zero;
          OP_ORI:   wval = s | imm_zero;
          OP_XORI:  wval = s ^ imm_zero;
          default:  wval = {w[15:0], 16'h0000};
        endcase
      end
      OP_COP0, OP_COP1, OP_COP2, OP_COP3, OP_LB, OP_LH, OP_LWL, OP_LW,
      OP_LBU, OP_LHU, OP_LWR, OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR,
      OP_LWC0, OP_LWC1, OP_LWC2, OP_LWC3, OP_SWC0, OP_SWC1, OP_SWC2, OP_HLE:
        st = STATUS_PASSED;
      default: st = STATUS_UNKNOWN;
    endcase
    if (wreg == 5'd0) we = 1'b0;
    if (!we) begin
      wreg = '0;
      wval = '0;
    end
    if (!taken) dest = '0;
    r.write_enable = we;
    r.write_register = wreg;
    r.write_value = wval;
    r.branch_taken = taken;
    r.branch_target = dest;
    r.status = st;
    return r;
  endfunction

  function automatic logic [31:0] enc_special(logic [5:0] funct, logic [4:0] rd,
                                              logic [4:0] shamt);
    return {OP_SPECIAL, 10'd0, rd, shamt, funct};
  endfunction

  function automatic logic [31:0] enc_imm(logic [5:0] opcode, logic [4:0] rt,
                                          logic [15:0] imm);
    return {opcode, 5'd0, rt, imm};
  endfunction

  function automatic result_t make_result(logic we, logic [4:0] wreg, logic [31:0] wval,
                                          logic taken, logic [31:0] dest, status_t st);
    result_t r;
    r.write_enable = we;
    r.write_register = wreg;
    r.write_value = wval;
    r.branch_taken = taken;
    r.branch_target = dest;
    r.status = st;
    return r;
  endfunction

  task automatic add_row(input logic [31:0] w, input logic [31:0] s,
                         input logic [31:0] t, input logic [31:0] nxt);
    directed_row_t row;
    row.item = {w, s, t, nxt};
    row.typed = 1'b0;
    row.want = '0;
    directed_rows.push_back(row);
  endtask

  task automatic add_typed(input logic [31:0] w, input logic [31:0] s,
                           input logic [31:0] t, input logic [31:0] nxt,
                           input result_t want);
    directed_row_t row;
    row.item = {w, s, t, nxt};
    row.typed = 1'b1;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  function automatic int unsigned random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 11))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      4: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic instr_t random_instruction();
    instr_t      item;
    logic [31:0] w;
    int unsigned pick;
    w = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      w[31:26] = OP_SPECIAL;
      if ($urandom_range(0, 19) != 0) w[5:0] = special_functs[$urandom_range(0, NumFuncts - 1)];
    end else if (pick < 52) begin
      w[31:26] = OP_REGIMM;
      case ($urandom_range(0, 4))
        0: w[20:16] = RI_BLTZ;
        1: w[20:16] = RI_BGEZ;
        2: w[20:16] = RI_BLTZAL;
        3: w[20:16] = RI_BGEZAL;
        default: w[20:16] = 5'($urandom);
      endcase
    end else if (pick < 80) begin
      w[31:26] = main_opcodes[$urandom_range(0, NumComputeOps - 1)];
    end else if (pick < 92) begin
      w[31:26] = main_opcodes[$urandom_range(0, NumOps - 1)];
    end
    item.instruction_word = w;
    item.source_value = random_operand();
    item.target_value = ($urandom_range(0, 3) == 0) ? item.source_value : random_operand();
    item.next_address = ($urandom_range(0, 9) == 0) ? random_operand() : $urandom;
    return item;
  endfunction

  task automatic drive_instruction(input instr_t item, input bit typed,
                                   input result_t want, input int unsigned gap);
    if (gap > 0) begin
      instr_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    instr <= item;
    instr_valid <= 1'b1;
    @(posedge clk);
    while (!instr_ready) @(posedge clk);
    expected_results.push_back(typed ? want : predict_execution(item));
    accepted_count++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    instr_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= ReportLimit)
        $display("result %0d: %s expected %h, got %h", result_count, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("result %0d: transaction arrived with nothing expected", result_count);
      end else begin
        want = expected_results.pop_front();
        report_field("write_enable", 32'(want.write_enable), 32'(result.write_enable));
        report_field("write_register", 32'(want.write_register), 32'(result.write_register));
        report_field("write_value", want.write_value, result.write_value);
        report_field("branch_taken", 32'(want.branch_taken), 32'(result.branch_taken));
        report_field("branch_target", want.branch_target, result.branch_target);
        report_field("status", 32'(want.status), 32'(result.status));
      end
      result_count++;
    end
  end

  always @(posedge clk) begin
    if (rst || (instr_valid && instr_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The receiver holds off once for a long stretch so that the unit fills up.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        result_ready <= 1'b0;
        stall_left--;
      end else begin
        result_ready <= 1'b1;
        if (!holdoff_done && accepted_count >= HoldoffAfter) begin
          stall_left = HoldoffCycles;
          holdoff_done = 1'b1;
        end else if ((result_count / 200) % 3 != 1) begin
          stall_left = random_gap();
        end
      end
    end
  end

  initial begin
    add_row(enc_special(FN_SLL, 5'd1, 5'd31), 32'h0, 32'hffff_ffff, 32'h0000_1004);
    add_typed(enc_special(FN_SRA, 5'd3, 5'd31), 32'h0, 32'h8000_0000, 32'h0000_1008,
              make_result(1'b1, 5'd3, 32'hffff_ffff, 1'b0, 32'h0, STATUS_DONE));
    add_row(enc_special(FN_SRLV, 5'd5, 5'd0), 32'hffff_ffe4, 32'h8000_0000, 32'h100c);
    add_typed(enc_special(FN_JR, 5'd0, 5'd0), 32'h1234_5678, 32'h0, 32'h0000_1010,
              make_result(1'b0, 5'd0, 32'h0, 1'b1, 32'h1234_5678, STATUS_DONE));
    add_typed(enc_special(FN_JALR, 5'd31, 5'd0), 32'h0, 32'h0, 32'hffff_fffc,
              make_result(1'b1, 5'd31, 32'h0, 1'b1, 32'h0, STATUS_DONE));
    add_typed(enc_special(FN_ADD, 5'd7, 5'd0), 32'h7fff_ffff, 32'h1, 32'h0000_1018,
              make_result(1'b0, 5'd0, 32'h0, 1'b0, 32'h0, STATUS_OVERFLOW));
    add_typed(enc_special(FN_SUB, 5'd8, 5'd0), 32'h8000_0000, 32'h1, 32'h0000_101c,
              make_result(1'b0, 5'd0, 32'h0, 1'b0, 32'h0, STATUS_OVERFLOW));
    add_typed(enc_special(FN_ADDU, 5'd0, 5'd0), 32'h1, 32'h2, 32'h0000_1020,
              make_result(1'b0, 5'd0, 32'h0, 1'b0, 32'h0, STATUS_DONE));
    add_typed(enc_special(FN_ADDU, 5'd9, 5'd0), 32'hffff_ffff, 32'h1, 32'h0000_1024,
              make_result(1'b1, 5'd9, 32'h0, 1'b0, 32'h0, STATUS_DONE));
    add_typed(enc_special(FN_NOR, 5'd14, 5'd0), 32'h0, 32'h0, 32'h0000_1028,
              make_result(1'b1, 5'd14, 32'hffff_ffff, 1'b0, 32'h0, STATUS_DONE));
    add_typed(enc_special(FN_SLT, 5'd15, 5'd0), 32'h8000_0000, 32'h1, 32'h0000_102c,
              make_result(1'b1, 5'd15, 32'h1, 1'b0, 32'h0, STATUS_DONE));
    add_typed(enc_special(FN_SLTU, 5'd16, 5'd0), 32'h8000_0000, 32'h1, 32'h0000_1030,
              make_result(1'b1, 5'd16, 32'h0, 1'b0, 32'h0, STATUS_DONE));
    add_typed(enc_special(FN_MULT, 5'd17, 5'd0), 32'h5, 32'h6, 32'h0000_1034,
              make_result(1'b0, 5'd0, 32'h0, 1'b0, 32'h0, STATUS_PASSED));
    add_typed(enc_special(FN_UNUSED, 5'd18, 5'd0), 32'h5, 32'h6, 32'h0000_1038,
              make_result(1'b0, 5'd0, 32'h0, 1'b0, 32'h0, STATUS_UNKNOWN));
    add_typed(enc_imm(OP_REGIMM, RI_UNUSED, 16'h0010), 32'h0, 32'h0, 32'h0000_103c,
              make_result(1'b0, 5'd0, 32'h0, 1'b0, 32'h0, STATUS_UNKNOWN));
    add_typed(enc_imm(OP_REGIMM, RI_BLTZAL, 16'h0010), 32'h0, 32'h0, 32'h0000_0100,
              make_result(1'b1, 5'd31, 32'h0000_0104, 1'b0, 32'h0, STATUS_DONE));
    add_row(enc_imm(OP_REGIMM, RI_BGEZAL, 16'h8000), 32'h0, 32'h0, 32'h0002_0000);
    add_row(enc_imm(OP_REGIMM, RI_BLTZ, 16'h7fff), 32'h8000_0000, 32'h0, 32'hffff_fff0);
    add_row({OP_JAL, 26'h3ff_ffff}, 32'h0, 32'h0, 32'hf000_0004);
    add_row(enc_imm(OP_BEQ, 5'd3, 16'hffff), 32'hdead_beef, 32'hdead_beef, 32'h0000_2000);
    add_row(enc_imm(OP_BLEZ, 5'd0, 16'h0004), 32'h0, 32'h0, 32'h0000_2004);
    add_typed(enc_imm(OP_ADDI, 5'd5, 16'h0001), 32'h7fff_ffff, 32'h0, 32'h0000_2008,
              make_result(1'b0, 5'd0, 32'h0, 1'b0, 32'h0, STATUS_OVERFLOW));
    add_typed(enc_imm(OP_ADDIU, 5'd0, 16'h1234), 32'h1, 32'h0, 32'h0000_200c,
              make_result(1'b0, 5'd0, 32'h0, 1'b0, 32'h0, STATUS_DONE));
    add_typed(enc_imm(OP_SLTIU, 5'd6, 16'hffff), 32'hffff_fffe, 32'h0, 32'h0000_2010,
              make_result(1'b1, 5'd6, 32'h1, 1'b0, 32'h0, STATUS_DONE));
    add_typed(enc_imm(OP_LUI, 5'd7, 16'hffff), 32'h0, 32'h0, 32'h0000_2014,
              make_result(1'b1, 5'd7, 32'hffff_0000, 1'b0, 32'h0, STATUS_DONE));
    add_typed(enc_imm(OP_LW, 5'd8, 16'h0000), 32'h0, 32'h0, 32'h0000_2018,
              make_result(1'b0, 5'd0, 32'h0, 1'b0, 32'h0, STATUS_PASSED));
    add_typed(enc_imm(OP_HLE, 5'd9, 16'h0000), 32'h0, 32'h0, 32'h0000_201c,
              make_result(1'b0, 5'd0, 32'h0, 1'b0, 32'h0, STATUS_PASSED));
    add_typed(enc_imm(OP_UNUSED, 5'd10, 16'hffff), 32'h0, 32'h0, 32'h0000_2020,
              make_result(1'b0, 5'd0, 32'h0, 1'b0, 32'h0, STATUS_UNKNOWN));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      drive_instruction(directed_rows[i].item, directed_rows[i].typed,
                        directed_rows[i].want, random_gap());
    wait_for_results();

    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i == RandomItems / 2) wait_for_results();
      drive_instruction(random_instruction(), 1'b0, '0,
                        ((i / 200) % 3 == 0) ? 0 : random_gap());
    end
    wait_for_results();
    repeat (DrainCycles) @(posedge clk);

    mismatch_count += expected_results.size();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
design/mieu_pkg.sv
design/mieu_stage.sv
design/mieu_exec.sv
design/mips_integer_execute_unit.sv
design/mieu_checker.sv
tb/testbench.sv
